FILE: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/qapc_pkg.sv
`default_nettype none
package qapc_pkg;

    localparam int CFG_W   = 8;
    localparam int CMD_W   = 2;
    localparam int PHASE_W = 3;
    localparam int CNT_OUT_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] VSYNC_MS = 8'd17;
    localparam logic [CFG_W-1:0] RST_WAIT = 8'(2 * 17);
    localparam logic [CFG_W-1:0] RST_MAXP = VSYNC_MS;
    localparam logic [CFG_W-1:0] RST_STOP = VSYNC_MS;

    localparam logic [CFG_IDX_W-1:0] CFG_WAIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP = 2'd2;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCHED  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

    localparam logic [PHASE_W-1:0] PH_IDLE       = 3'd0;
    localparam logic [PHASE_W-1:0] PH_WAITING    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CHECKING   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PREEMPTING = 3'd3;
    localparam logic [PHASE_W-1:0] PH_WOULD      = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             sched_value;
    } t_in;

    typedef struct packed {
        logic                 preempt_active;
        logic [PHASE_W-1:0]   phase;
        logic [CNT_OUT_W-1:0] pending_count;
        logic                 rejected;
    } t_out;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    // One-shot timer load: a zero delay fires on the next tick.
    function automatic logic [CFG_W-1:0] f_timer_load(input logic [CFG_W-1:0] d);
        return (d == '0) ? CFG_W'(1) : d;
    endfunction

endpackage
`default_nettype wire

FILE: src/qapc_fifo.sv
`default_nettype none
module qapc_fifo #(
    parameter int DEPTH = 64,
    parameter int TW    = 32,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire qapc_pkg::t_fifo_ctl i_ctl,
    input  wire logic [TW-1:0]       i_wr_time,
    output logic [CW-1:0]            o_count,
    output logic [CW-1:0]            o_count_nxt,
    output logic [TW-1:0]            o_head_time_nxt
);
    import qapc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [TW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count;
    logic [TW-1:0] r_head_time;
    logic [TW-1:0] r_rd_data;
    logic          r_byp;
    logic [TW-1:0] r_byp_data;

    logic [CW:0]   w_wsum;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [TW-1:0] w_next_time;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] a);
        return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    assign w_wsum  = {1'b0, CW'(r_head)} + {1'b0, r_count};
    assign w_waddr = (w_wsum >= (CW+1)'(DEPTH)) ? AW'(w_wsum - (CW+1)'(DEPTH)) : AW'(w_wsum);
    assign n_head  = i_ctl.pop ? f_inc(r_head) : r_head;
    // Prefetch the entry behind the head as it stands after this cycle.
    assign w_raddr = f_inc(n_head);

    // An entry written on the same edge it was read comes from the bypass register, not the stale memory read.
    assign w_next_time = r_byp ? r_byp_data : r_rd_data;

    always_comb begin
        o_count_nxt     = r_count;
        o_head_time_nxt = r_head_time;
        if (i_ctl.push) begin
            o_count_nxt = r_count + CW'(1);
            if (r_count == '0) begin
                o_head_time_nxt = i_wr_time;
            end
        end else if (i_ctl.pop) begin
            o_count_nxt     = r_count - CW'(1);
            o_head_time_nxt = w_next_time;
        end
    end

    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[w_waddr] <= i_wr_time;
        end
        r_rd_data   <= r_mem[w_raddr];
        r_byp_data  <= i_wr_time;
        r_head_time <= o_head_time_nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_byp   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= o_count_nxt;
            r_byp   <= i_ctl.push && (w_waddr == w_raddr);
        end
    end

endmodule
`default_nettype wire

FILE: src/queue_age_preemption_controller.sv
// A transaction in the input register goes through the phase update, a single pass of
// logic, and its result is captured in the result register.
// Throughput: one transaction per cycle unless the output stalls.
// Reset (synchronous, active low) restores config defaults, idle phase, empty queue,
// scheduled set; timestamp storage is not cleared.
`default_nettype none
module queue_age_preemption_controller #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_BITS   = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire qapc_pkg::t_in                      i_in,
    output logic                                    o_in_stall,
    output logic                                    o_out_valid,
    output qapc_pkg::t_out                          o_out,
    input  wire logic                               i_out_stall,
    input  wire logic                               i_cfg_we,
    input  wire logic [qapc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [qapc_pkg::CFG_W-1:0]         i_cfg_wdata
);
    import qapc_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = TIME_BITS;

    logic             r_in_valid;
    t_in              r_in;
    logic             r_out_valid;
    t_out             r_out;

    logic [CFG_W-1:0] r_wait, r_maxp, r_stop;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [TW-1:0]      r_now;
    logic [CFG_W-1:0]   r_left, n_left;
    logic               r_running, n_running;
    logic [CFG_W-1:0]   r_saved, n_saved;
    logic               r_sched;
    logic               r_flag, n_flag;

    logic             w_fire;
    t_fifo_ctl        w_fctl;
    logic [CW-1:0]    w_count, w_count_nxt;
    logic [TW-1:0]    w_head_time;
    logic             w_full, w_empty_now, w_empty;

    logic [TW-1:0]    e_now;
    logic [CFG_W-1:0] e_left;
    logic             e_running, e_sched, e_upd, e_rej;

    logic [TW-1:0]    w_age;
    logic             w_lt_wait, w_lt_stop;
    logic [CFG_W-1:0] w_wait_rem;
    t_out             w_res;

    qapc_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .TW    (TW)
    ) u_fifo (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_fctl),
        .i_wr_time       (r_now),
        .o_count         (w_count),
        .o_count_nxt     (w_count_nxt),
        .o_head_time_nxt (w_head_time)
    );

    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;

    assign w_full      = (w_count == CW'(QUEUE_DEPTH));
    assign w_empty_now = (w_count == '0);
    assign w_fctl.push = w_fire && (r_in.cmd == CMD_PUSH) && !w_full;
    assign w_fctl.pop  = w_fire && (r_in.cmd == CMD_FINISH) && !w_empty_now;
    assign w_empty     = (w_count_nxt == '0);

    // Event stage: time, timer countdown, scheduled flag, reject flag, update request.
    always_comb begin
        e_now     = r_now;
        e_left    = r_left;
        e_running = r_running;
        e_sched   = r_sched;
        e_upd     = 1'b0;
        e_rej     = 1'b0;
        case (r_in.cmd)
            CMD_PUSH: begin
                e_rej = w_full;
                e_upd = !w_full;
            end
            CMD_FINISH: begin
                e_rej = w_empty_now;
                e_upd = !w_empty_now;
            end
            CMD_SCHED: begin
                e_sched = r_in.sched_value;
                e_upd   = (r_in.sched_value != r_sched);
            end
            default: begin
                e_now = r_now + TW'(1);
                if (r_running) begin
                    if (r_left != '0) begin
                        e_left = r_left - CFG_W'(1);
                    end
                    if (e_left == '0) begin
                        e_running = 1'b0;
                        e_upd     = 1'b1;
                    end
                end
            end
        endcase
    end

    assign w_age      = e_now - w_head_time;
    assign w_lt_wait  = (w_age < TW'(r_wait));
    assign w_lt_stop  = (w_age < TW'(r_stop));
    assign w_wait_rem = r_wait - w_age[CFG_W-1:0];

    // Phase machine, applied after the event.
    always_comb begin
        n_phase   = r_phase;
        n_flag    = r_flag;
        n_saved   = r_saved;
        n_left    = e_left;
        n_running = e_running;
        if (e_upd) begin
            unique case (r_phase) inside
                PH_IDLE: begin
                    if (!w_empty) begin
                        n_phase   = PH_WAITING;
                        n_left    = f_timer_load(r_wait);
                        n_running = 1'b1;
                    end
                end
                PH_WAITING, PH_CHECKING: begin
                    if (r_phase == PH_CHECKING || !e_running) begin
                        n_phase = PH_CHECKING;
                        if (!w_empty) begin
                            if (w_lt_wait) begin
                                n_left    = f_timer_load(w_wait_rem);
                                n_running = 1'b1;
                            end else if (!e_sched) begin
                                n_phase   = PH_WOULD;
                                n_flag    = 1'b0;
                                n_left    = '0;
                                n_running = 1'b0;
                            end else begin
                                n_phase   = PH_PREEMPTING;
                                n_flag    = 1'b1;
                                n_left    = f_timer_load(r_saved);
                                n_running = 1'b1;
                            end
                        end
                    end
                end
                PH_PREEMPTING: begin
                    if (!e_running || w_empty || w_lt_stop) begin
                        n_phase   = w_empty ? PH_IDLE : PH_WAITING;
                        n_flag    = 1'b0;
                        n_saved   = r_maxp;
                        n_left    = w_empty ? '0 : f_timer_load(r_wait);
                        n_running = !w_empty;
                    end else if (!e_sched) begin
                        // Descheduled mid-episode: keep what is left for later.
                        n_saved   = e_left;
                        n_left    = '0;
                        n_running = 1'b0;
                        n_phase   = PH_WOULD;
                        n_flag    = 1'b0;
                    end
                end
                PH_WOULD: begin
                    if (w_empty || w_lt_stop) begin
                        n_phase   = w_empty ? PH_IDLE : PH_WAITING;
                        n_flag    = 1'b0;
                        n_saved   = r_maxp;
                        n_left    = w_empty ? '0 : f_timer_load(r_wait);
                        n_running = !w_empty;
                    end else if (e_sched) begin
                        n_phase   = PH_PREEMPTING;
                        n_flag    = 1'b1;
                        n_left    = f_timer_load(r_saved);
                        n_running = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign w_res.preempt_active = n_flag;
    assign w_res.phase          = n_phase;
    assign w_res.pending_count  = CNT_OUT_W'(w_count_nxt);
    assign w_res.rejected       = e_rej;

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in;
        end
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wait      <= RST_WAIT;
            r_maxp      <= RST_MAXP;
            r_stop      <= RST_STOP;
            r_phase     <= PH_IDLE;
            r_now       <= '0;
            r_left      <= '0;
            r_running   <= 1'b0;
            r_saved     <= RST_MAXP;
            r_sched     <= 1'b1;
            r_flag      <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WAIT: r_wait <= i_cfg_wdata;
                    CFG_MAXP: r_maxp <= i_cfg_wdata;
                    CFG_STOP: r_stop <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (w_fire) begin
                r_phase   <= n_phase;
                r_now     <= e_now;
                r_left    <= n_left;
                r_running <= n_running;
                r_saved   <= n_saved;
                r_sched   <= e_sched;
                r_flag    <= n_flag;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

FILE: src/qapc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module qapc_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_out_stall,
    input  wire logic           o_out_valid,
    input  wire qapc_pkg::t_out o_out
);
    import qapc_pkg::*;

    // Preempt output is raised exactly in the preempting phase.
    `ASSERT_IMP(a_flag_phase, i_clk, i_rst_n, o_out_valid, o_out.preempt_active == (o_out.phase == PH_PREEMPTING))

    // The machine only rests in idle with nothing queued.
    `ASSERT_IMP(a_idle_empty, i_clk, i_rst_n, o_out_valid && (o_out.phase == PH_IDLE), o_out.pending_count == '0)

    // A stalled result holds.
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

endmodule

bind queue_age_preemption_controller qapc_checker u_qapc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_stall (i_out_stall),
    .o_out_valid (o_out_valid),
    .o_out       (o_out)
);
`default_nettype wire

FILE: verif/tb_queue_age_preemption_controller.sv
`default_nettype none
module tb_queue_age_preemption_controller;
    import qapc_pkg::*;

    localparam int QDEPTH     = 64;
    localparam int QUIET_MAX  = 2000;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in                  i_in        = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out                 o_out;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    queue_age_preemption_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- controller shadow state ----------------
    bit [CFG_W-1:0]   m_wait, m_maxp, m_stop;
    bit [PHASE_W-1:0] m_phase;
    bit [31:0]        m_now;
    bit [31:0]        m_stamp [QDEPTH];
    bit [5:0]         m_head;
    bit [6:0]         m_count;
    bit [7:0]         m_tleft;
    bit               m_trun;
    bit [7:0]         m_saved;
    bit               m_sched;
    bit               m_pflag;

    function automatic bit [31:0] oldest_age();
        return m_now - m_stamp[m_head];
    endfunction

    function automatic void arm_timer(bit [7:0] d);
        m_tleft = (d == 8'd0) ? 8'd1 : d;
        m_trun  = 1'b1;
    endfunction

    function automatic void disarm_timer();
        m_trun  = 1'b0;
        m_tleft = 8'd0;
    endfunction

    function automatic void enter_preempt();
        m_phase = PH_PREEMPTING;
        m_pflag = 1'b1;
        arm_timer(m_saved);
    endfunction

    function automatic void enter_would();
        m_phase = PH_WOULD;
        m_pflag = 1'b0;
    endfunction

    function automatic bit backlog_is_fresh();
        return (m_count == 0) || (oldest_age() < {24'd0, m_stop});
    endfunction

    function automatic void start_wait();
        if (m_count != 0) begin
            m_phase = PH_WAITING;
            arm_timer(m_wait);
        end
    endfunction

    function automatic void back_to_idle();
        m_phase = PH_IDLE;
        m_pflag = 1'b0;
        m_saved = m_maxp;
        disarm_timer();
        start_wait();
    endfunction

    function automatic void check_age();
        bit [31:0] age;
        if (m_count == 0) return;
        age = oldest_age();
        if (age < {24'd0, m_wait}) begin
            arm_timer(m_wait - age[7:0]);
        end else begin
            disarm_timer();
            if (!m_sched) enter_would();
            else enter_preempt();
        end
    endfunction

    function automatic void advance_phase();
        case (m_phase)
            PH_IDLE: start_wait();
            PH_WAITING: begin
                if (!m_trun) begin
                    m_phase = PH_CHECKING;
                    check_age();
                end
            end
            PH_CHECKING: check_age();
            PH_PREEMPTING: begin
                if (!m_trun || backlog_is_fresh()) begin
                    back_to_idle();
                end else if (!m_sched) begin
                    // descheduled mid-episode: keep what is left of the preempt budget
                    m_saved = m_tleft;
                    disarm_timer();
                    enter_would();
                end
            end
            PH_WOULD: begin
                if (backlog_is_fresh()) back_to_idle();
                else if (m_sched) enter_preempt();
            end
            default: m_phase = PH_IDLE;
        endcase
    endfunction

    function automatic void reset_shadow();
        m_wait  = RST_WAIT;
        m_maxp  = RST_MAXP;
        m_stop  = RST_STOP;
        m_phase = PH_IDLE;
        m_now   = '0;
        m_head  = '0;
        m_count = '0;
        m_tleft = '0;
        m_trun  = 1'b0;
        m_saved = RST_MAXP;
        m_sched = 1'b1;
        m_pflag = 1'b0;
    endfunction

    function automatic t_out next_status(t_in ev);
        t_out s;
        bit   rej;
        rej = 1'b0;
        case (ev.cmd)
            CMD_PUSH: begin
                if (m_count >= QDEPTH) begin
                    rej = 1'b1;
                end else begin
                    m_stamp[m_head + m_count[5:0]] = m_now;
                    m_count++;
                    advance_phase();
                end
            end
            CMD_FINISH: begin
                if (m_count == 0) begin
                    rej = 1'b1;
                end else begin
                    m_head++;
                    m_count--;
                    advance_phase();
                end
            end
            CMD_SCHED: begin
                if (ev.sched_value != m_sched) begin
                    m_sched = ev.sched_value;
                    advance_phase();
                end
            end
            CMD_TICK: begin
                m_now++;
                if (m_trun) begin
                    if (m_tleft != 0) m_tleft--;
                    if (m_tleft == 0) begin
                        m_trun = 1'b0;
                        advance_phase();
                    end
                end
            end
            default: ;
        endcase
        s.preempt_active = m_pflag;
        s.phase          = m_phase;
        s.pending_count  = m_count;
        s.rejected       = rej;
        return s;
    endfunction

    // ---------------- driver / monitor ----------------
    t_in  event_backlog [$];
    t_out due_status [$];
    int   planned, resolved, errors, n_rejects, n_preempt, n_settings;
    int   send_idle_pct, recv_idle_pct;
    int   quiet_cycles;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_fire) due_status.insert(due_status.size(), next_status(i_in));
            if (!i_in_valid || !o_in_stall) begin
                if (event_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in       <= event_backlog[0];
                    i_in_valid <= 1'b1;
                    event_backlog.delete(0);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out exp_s;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (out_fire) begin
                if (due_status.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected status transaction act=%0b phase=%0d cnt=%0d rej=%0b",
                             $time, o_out.preempt_active, o_out.phase, o_out.pending_count,
                             o_out.rejected);
                end else begin
                    exp_s = due_status[0];
                    due_status.delete(0);
                    resolved++;
                    if (exp_s.rejected) n_rejects++;
                    if (exp_s.preempt_active) n_preempt++;
                    if (o_out !== exp_s) begin
                        errors++;
                        $display("%0t: status mismatch: expected act=%0b phase=%0d cnt=%0d rej=%0b, got act=%0b phase=%0d cnt=%0d rej=%0b",
                                 $time, exp_s.preempt_active, exp_s.phase,
                                 exp_s.pending_count, exp_s.rejected, o_out.preempt_active,
                                 o_out.phase, o_out.pending_count, o_out.rejected);
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || in_fire || out_fire) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_MAX);
        $display("%0t: no transaction for %0d cycles", $time, QUIET_MAX);
        $display("tb_queue_age_preemption_controller: FAIL");
        $finish;
    end

    // ---------------- stimulus ----------------
    task automatic queue_event(logic [CMD_W-1:0] cmd, logic sv);
        t_in ev;
        ev.cmd         = cmd;
        ev.sched_value = sv;
        event_backlog.insert(event_backlog.size(), ev);
        planned++;
    endtask

    task automatic queue_noise(int n);
        repeat (n) queue_event(CMD_W'($urandom_range(3)), 1'($urandom_range(1)));
    endtask

    // all queued transactions have come back as results
    task automatic wait_drained();
        do @(posedge i_clk);
        while (resolved != planned);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_WAIT: m_wait = val;
            CFG_MAXP: m_maxp = val;
            CFG_STOP: m_stop = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(int w, int m, int s);
        repeat (2) @(posedge i_clk);
        write_reg(CFG_WAIT, CFG_W'(w));
        write_reg(CFG_MAXP, CFG_W'(m));
        write_reg(CFG_STOP, CFG_W'(s));
        n_settings++;
    endtask

    // a burst of messages, enough ticks to age them toward preemption with
    // schedule flips and traffic mixed in, then a drain of the queue
    task automatic plan_episode();
        int pushes, span, cap;
        pushes = $urandom_range(1, 5);
        cap    = (m_maxp > 30) ? 30 : int'(m_maxp);
        span   = int'(m_wait) + $urandom_range(0, cap + 8);
        if ($urandom_range(3) == 0) span = $urandom_range(0, int'(m_wait));
        repeat (pushes) queue_event(CMD_PUSH, 1'($urandom_range(1)));
        repeat (span) begin
            case ($urandom_range(19))
                0, 1: queue_event(CMD_SCHED, 1'($urandom_range(1)));
                2:    queue_event(CMD_PUSH, 1'($urandom_range(1)));
                3:    queue_event(CMD_FINISH, 1'($urandom_range(1)));
                default: queue_event(CMD_TICK, 1'($urandom_range(1)));
            endcase
        end
        repeat (pushes + $urandom_range(1)) begin
            queue_event(CMD_FINISH, 1'($urandom_range(1)));
            if ($urandom_range(1)) queue_event(CMD_TICK, 1'($urandom_range(1)));
        end
        if ($urandom_range(2) == 0) queue_event(CMD_SCHED, 1'b1);
    endtask

    task automatic run_segment(int w, int m, int s, int target, bit flood);
        int  first;
        bit  paused;
        wait_drained();
        set_config(w, m, s);
        first  = planned;
        paused = 1'b0;
        if (flood) begin
            // overfill, let the full queue age into preemption, then overdrain
            repeat (QDEPTH + 3) queue_event(CMD_PUSH, 1'($urandom_range(1)));
            repeat (int'(m_wait) + 2) queue_event(CMD_TICK, 1'($urandom_range(1)));
            repeat (QDEPTH + 3) queue_event(CMD_FINISH, 1'($urandom_range(1)));
        end
        while (planned - first < target) begin
            if (!paused && planned - first >= target / 2) begin
                paused = 1'b1;
                wait_drained();
            end
            if ($urandom_range(4) == 0) queue_noise($urandom_range(1, 6));
            else plan_episode();
        end
    endtask

    initial begin
        reset_shadow();
        send_idle_pct = 37;
        recv_idle_pct = 49;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings first
        queue_event(CMD_FINISH, 1'b0);   // finish on empty queue
        queue_event(CMD_SCHED, 1'b1);    // scheduled already set
        queue_event(CMD_TICK, 1'b0);
        wait_drained();
        // preempt budget still holds the reset value until the next idle
        set_config(2, 3, 1);
        queue_event(CMD_PUSH, 1'b1);
        queue_event(CMD_TICK, 1'b1);
        queue_event(CMD_TICK, 1'b0);     // expiry -> checking -> preempting
        queue_event(CMD_SCHED, 1'b0);    // descheduled while preempting
        queue_event(CMD_SCHED, 1'b0);
        queue_event(CMD_SCHED, 1'b1);    // resume with saved time
        queue_event(CMD_PUSH, 1'b0);
        queue_event(CMD_FINISH, 1'b1);   // young oldest -> back to waiting
        queue_event(CMD_TICK, 1'b0);
        queue_event(CMD_TICK, 1'b1);
        repeat (3) queue_event(CMD_TICK, 1'b0);  // preempt time runs out
        queue_event(CMD_SCHED, 1'b0);
        queue_event(CMD_TICK, 1'b1);
        queue_event(CMD_TICK, 1'b0);     // would preempt, descheduled
        queue_event(CMD_FINISH, 1'b0);   // queue empties
        queue_event(CMD_FINISH, 1'b1);
        queue_event(CMD_SCHED, 1'b1);
        queue_event(CMD_PUSH, 1'b0);
        queue_event(CMD_FINISH, 1'b0);   // emptied while waiting
        queue_event(CMD_TICK, 1'b1);
        queue_event(CMD_TICK, 1'b0);     // checking with nothing queued
        queue_event(CMD_PUSH, 1'b1);

        run_segment(1, 1, 1, 150, 1'b0);
        run_segment(255, 255, 255, 120, 1'b0);
        wait_drained();
        send_idle_pct = 49;
        recv_idle_pct = 37;
        run_segment(6, 4, 3, 150, 1'b1);
        run_segment($urandom_range(1, 40), $urandom_range(1, 30), $urandom_range(1, 40),
                    150, 1'b0);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_segment(3, 255, 1, 150, 1'b0);
        run_segment(20, 1, 255, 150, 1'b0);

        wait_drained();
        repeat (4) @(posedge i_clk);
        $display("Ran %0d queue events over %0d register settings; %0d status results checked,",
                 planned, n_settings + 1, resolved);
        $display("  %0d of them rejected, %0d with preemption raised, %0d mismatches.",
                 n_rejects, n_preempt, errors);
        if (errors == 0 && due_status.size() == 0) begin
            $display("tb_queue_age_preemption_controller: PASS");
        end else begin
            $display("tb_queue_age_preemption_controller: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+src
src/qapc_pkg.sv
src/qapc_fifo.sv
src/queue_age_preemption_controller.sv
src/qapc_checker.sv
verif/tb_queue_age_preemption_controller.sv
